### rtl/core/assert_macros.svh
// Assertion helpers used by linear_blend_skinning.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LBS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lbs assertion failed");

`define LBS_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("lbs assertion failed");

`else

`define LBS_ASSERT(label, clk, rst_n, prop)

`define LBS_ASSERT_NEXT(label, clk, rst_n, cond, nxt)

`endif

`endif

### rtl/core/lbs_pkg.sv
package lbs_pkg;

    localparam int MAX_JOINTS   = 64;
    localparam int MAX_VERTICES = 1024;
    localparam int FRAC_BITS    = 16;
    localparam int WEIGHT_FRAC  = 16;
    localparam int ELEMS        = 12;

    // Field widths of the channels.
    localparam int KIND_W  = 2;
    localparam int JOINT_W = 6;
    localparam int ELEM_W  = 4;
    localparam int VTX_W   = 10;
    localparam int COORD_W = 32;
    localparam int WGT_W   = 17;

    localparam int MAT_DEPTH = MAX_JOINTS * ELEMS;
    localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int VTX_AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    // Shared multiplier: signed operands one bit wider than a coordinate.
    localparam int MUL_W  = COORD_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Row sum: three shifted products plus the translation.
    localparam int T_W     = 2 * COORD_W - FRAC_BITS + 3;
    localparam int DEL_W   = MUL_W + WGT_W + 1 - WEIGHT_FRAC;
    localparam int SUM_W   = DEL_W + 1;
    localparam int SAT_W   = (T_W > SUM_W) ? T_W : SUM_W;

    localparam logic [ELEM_W-1:0] LAST_ELEM = ELEM_W'(ELEMS - 1);
    localparam logic [1:0]        TRANS_COL = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        K_MATRIX = 2'd0,
        K_BASE   = 2'd1,
        K_BLEND  = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SAT_W-1:0] x
    );
        logic hi_zero;
        logic hi_one;
        hi_zero = ~|x[SAT_W-1:COORD_W-1];
        hi_one  = &x[SAT_W-1:COORD_W-1];
        if (hi_zero || hi_one) begin
            return x[COORD_W-1:0];
        end else if (x[SAT_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    function automatic logic [MAT_AW-1:0] mat_addr(
        input logic [JOINT_W-1:0] j,
        input logic [ELEM_W-1:0]  e
    );
        return MAT_AW'(j) * MAT_AW'(ELEMS) + MAT_AW'(e);
    endfunction

endpackage

### rtl/core/lbs_if.sv
interface lbs_in_if;
    logic                                   valid;
    logic                                   ready;
    lbs_pkg::t_kind                         kind;
    logic [lbs_pkg::JOINT_W-1:0]            joint_index;
    logic [lbs_pkg::ELEM_W-1:0]             element_index;
    logic signed [lbs_pkg::COORD_W-1:0]     matrix_value;
    logic [lbs_pkg::VTX_W-1:0]              vertex_index;
    logic signed [lbs_pkg::COORD_W-1:0]     coord_x;
    logic signed [lbs_pkg::COORD_W-1:0]     coord_y;
    logic signed [lbs_pkg::COORD_W-1:0]     coord_z;
    logic [lbs_pkg::WGT_W-1:0]              weight;

    modport source (
        output valid, kind, joint_index, element_index, matrix_value,
               vertex_index, coord_x, coord_y, coord_z, weight,
        input  ready
    );
    modport sink (
        input  valid, kind, joint_index, element_index, matrix_value,
               vertex_index, coord_x, coord_y, coord_z, weight,
        output ready
    );
endinterface

interface lbs_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [lbs_pkg::VTX_W-1:0]              out_vertex;
    logic signed [lbs_pkg::COORD_W-1:0]     pos_x;
    logic signed [lbs_pkg::COORD_W-1:0]     pos_y;
    logic signed [lbs_pkg::COORD_W-1:0]     pos_z;

    modport source (output valid, out_vertex, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, out_vertex, pos_x, pos_y, pos_z, output ready);
endinterface

### rtl/core/lbs_ram.sv
module lbs_ram #(
    parameter int W = 32,
    parameter int D = 1024,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lbs_mul.sv
module lbs_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [lbs_pkg::MUL_W-1:0]    i_a,
    input  logic signed [lbs_pkg::MUL_W-1:0]    i_b,
    output logic signed [lbs_pkg::PROD_W-1:0]   o_prod
);

    logic signed [lbs_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

### rtl/core/linear_blend_skinning.sv
// Linear blend skinning engine. Matrix element writes (kind 0) and base vertex loads
// (kind 1) are written as they are accepted. A read (kind 3) waits until the output
// register is free; its result sits in that register, so the next transfer is accepted
// while it waits. A weight record (kind 2) holds the input off until its write-back:
// the twelve matrix entries are fetched one at a time from a single-port-read memory,
// and one shared 33x33 multiplier forms, row by row, three rotation products and then
// that row's weighted difference, each followed by its accumulate step. Memories hold
// no reset value; every entry must be written before it is read.
`include "assert_macros.svh"

module linear_blend_skinning (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbs_in_if.sink      i_in,
    lbs_out_if.source   o_out
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOADB = 9'b000000010,
        S_MMUL  = 9'b000000100,
        S_MSUM  = 9'b000001000,
        S_MWAIT = 9'b000010000,
        S_WMUL  = 9'b000100000,
        S_WACC  = 9'b001000000,
        S_WRB   = 9'b010000000,
        S_RDOUT = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [lbs_pkg::VTX_AW-1:0]          r_vtx, n_vtx;
    logic [lbs_pkg::VTX_W-1:0]           r_vidx, n_vidx;
    logic                                r_vok, n_vok;
    logic [lbs_pkg::JOINT_W-1:0]         r_jnt, n_jnt;
    logic [lbs_pkg::WGT_W-1:0]           r_w, n_w;
    logic [lbs_pkg::ELEM_W-1:0]          r_elem, n_elem;
    logic signed [lbs_pkg::COORD_W-1:0]  r_b [3];
    logic signed [lbs_pkg::COORD_W-1:0]  n_b [3];
    logic signed [lbs_pkg::COORD_W-1:0]  r_acc [3];
    logic signed [lbs_pkg::COORD_W-1:0]  n_acc [3];
    logic signed [lbs_pkg::T_W-1:0]      r_t, n_t;

    logic                                r_out_valid, n_out_valid;
    logic [lbs_pkg::VTX_W-1:0]           r_out_vtx;
    logic signed [lbs_pkg::COORD_W-1:0]  r_pos [3];
    logic                                out_load;

    logic                                in_fire;
    logic                                in_vok;
    logic                                in_jok;
    logic                                in_eok;
    logic [lbs_pkg::VTX_AW-1:0]          in_vaddr;

    logic                                mat_we;
    logic                                base_we;
    logic                                acc_we;
    logic                                wrb;
    logic [lbs_pkg::VTX_AW-1:0]          vtx_raddr;
    logic [lbs_pkg::VTX_AW-1:0]          acc_waddr;
    logic [3*lbs_pkg::COORD_W-1:0]       in_coords;
    logic [3*lbs_pkg::COORD_W-1:0]       acc_wdata;
    logic [3*lbs_pkg::COORD_W-1:0]       base_rd;
    logic [3*lbs_pkg::COORD_W-1:0]       acc_rd;
    logic signed [lbs_pkg::COORD_W-1:0]  mat_rd;

    logic [1:0]                          col;
    logic [1:0]                          row;
    logic signed [lbs_pkg::COORD_W-1:0]  b_col;
    logic signed [lbs_pkg::COORD_W-1:0]  b_row;
    logic signed [lbs_pkg::COORD_W-1:0]  acc_row;
    logic signed [lbs_pkg::COORD_W-1:0]  t_sat;
    logic signed [lbs_pkg::MUL_W-1:0]    d_row;
    logic signed [lbs_pkg::DEL_W-1:0]    delta;
    logic signed [lbs_pkg::SUM_W-1:0]    acc_sum;
    logic signed [lbs_pkg::COORD_W-1:0]  acc_new;

    logic                                mul_en;
    logic signed [lbs_pkg::MUL_W-1:0]    mul_a;
    logic signed [lbs_pkg::MUL_W-1:0]    mul_b;
    logic signed [lbs_pkg::PROD_W-1:0]   prod;

    // Input decode.
    assign in_fire  = i_in.valid & i_in.ready;
    assign in_vok   = int'(i_in.vertex_index) < lbs_pkg::MAX_VERTICES;
    assign in_jok   = int'(i_in.joint_index) < lbs_pkg::MAX_JOINTS;
    assign in_eok   = int'(i_in.element_index) < lbs_pkg::ELEMS;
    assign in_vaddr = lbs_pkg::VTX_AW'(i_in.vertex_index);
    assign in_coords = {i_in.coord_x, i_in.coord_y, i_in.coord_z};

    assign mat_we  = in_fire && (i_in.kind == lbs_pkg::K_MATRIX) && in_jok && in_eok;
    assign base_we = in_fire && (i_in.kind == lbs_pkg::K_BASE) && in_vok;
    assign wrb     = (r_state == S_WRB);
    assign acc_we  = base_we | wrb;

    // Loading a base vertex also restarts its accumulated position from the base.
    assign acc_waddr = wrb ? r_vtx : in_vaddr;
    assign acc_wdata = wrb ? {r_acc[0], r_acc[1], r_acc[2]} : in_coords;
    assign vtx_raddr = (r_state == S_IDLE) ? in_vaddr : r_vtx;

    lbs_ram #(.W(lbs_pkg::COORD_W), .D(lbs_pkg::MAT_DEPTH)) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (lbs_pkg::mat_addr(i_in.joint_index, i_in.element_index)),
        .i_wdata (i_in.matrix_value),
        .i_raddr (lbs_pkg::mat_addr(r_jnt, r_elem)),
        .o_rdata (mat_rd)
    );

    lbs_ram #(.W(3 * lbs_pkg::COORD_W), .D(lbs_pkg::MAX_VERTICES)) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (base_we),
        .i_waddr (in_vaddr),
        .i_wdata (in_coords),
        .i_raddr (vtx_raddr),
        .o_rdata (base_rd)
    );

    lbs_ram #(.W(3 * lbs_pkg::COORD_W), .D(lbs_pkg::MAX_VERTICES)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (vtx_raddr),
        .o_rdata (acc_rd)
    );

    // Element r*4+c: columns 0 to 2 are rotation, column 3 the translation.
    assign col = r_elem[1:0];
    assign row = r_elem[3:2];

    always_comb begin
        unique case (col)
            2'd0:    b_col = r_b[0];
            2'd1:    b_col = r_b[1];
            default: b_col = r_b[2];
        endcase
        unique case (row)
            2'd0: begin
                b_row   = r_b[0];
                acc_row = r_acc[0];
            end
            2'd1: begin
                b_row   = r_b[1];
                acc_row = r_acc[1];
            end
            default: begin
                b_row   = r_b[2];
                acc_row = r_acc[2];
            end
        endcase
    end

    assign t_sat   = lbs_pkg::sat_coord(lbs_pkg::SAT_W'(r_t));
    assign d_row   = lbs_pkg::MUL_W'(t_sat) - lbs_pkg::MUL_W'(b_row);
    assign delta   = lbs_pkg::DEL_W'(prod >>> lbs_pkg::WEIGHT_FRAC);
    assign acc_sum = lbs_pkg::SUM_W'(acc_row) + lbs_pkg::SUM_W'(delta);
    assign acc_new = lbs_pkg::sat_coord(lbs_pkg::SAT_W'(acc_sum));

    assign mul_en = (r_state == S_MMUL) || (r_state == S_WMUL);

    always_comb begin
        if (r_state == S_WMUL) begin
            mul_a = d_row;
            mul_b = lbs_pkg::MUL_W'(r_w);
        end else begin
            mul_a = lbs_pkg::MUL_W'(mat_rd);
            mul_b = lbs_pkg::MUL_W'(b_col);
        end
    end

    lbs_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        n_state     = r_state;
        n_vtx       = r_vtx;
        n_vidx      = r_vidx;
        n_vok       = r_vok;
        n_jnt       = r_jnt;
        n_w         = r_w;
        n_elem      = r_elem;
        n_b         = r_b;
        n_acc       = r_acc;
        n_t         = r_t;
        out_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_vtx  = in_vaddr;
                    n_vidx = i_in.vertex_index;
                    n_vok  = in_vok;
                    n_jnt  = i_in.joint_index;
                    n_w    = i_in.weight;
                    n_elem = '0;
                    unique case (i_in.kind)
                        lbs_pkg::K_BLEND: begin
                            if (in_vok && in_jok) begin
                                n_state = S_LOADB;
                            end
                        end
                        lbs_pkg::K_READ: begin
                            n_state = S_RDOUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOADB: begin
                n_b[0]   = base_rd[3*lbs_pkg::COORD_W-1:2*lbs_pkg::COORD_W];
                n_b[1]   = base_rd[2*lbs_pkg::COORD_W-1:lbs_pkg::COORD_W];
                n_b[2]   = base_rd[lbs_pkg::COORD_W-1:0];
                n_acc[0] = acc_rd[3*lbs_pkg::COORD_W-1:2*lbs_pkg::COORD_W];
                n_acc[1] = acc_rd[2*lbs_pkg::COORD_W-1:lbs_pkg::COORD_W];
                n_acc[2] = acc_rd[lbs_pkg::COORD_W-1:0];
                n_t      = '0;
                n_state  = S_MMUL;
            end
            S_MMUL: begin
                if (col == lbs_pkg::TRANS_COL) begin
                    n_t     = r_t + lbs_pkg::T_W'(mat_rd);
                    n_state = S_WMUL;
                end else begin
                    n_state = S_MSUM;
                end
            end
            S_MSUM: begin
                n_t     = r_t + lbs_pkg::T_W'(prod >>> lbs_pkg::FRAC_BITS);
                n_elem  = r_elem + 1'b1;
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                n_state = S_MMUL;
            end
            S_WMUL: begin
                n_state = S_WACC;
            end
            S_WACC: begin
                n_acc[row] = acc_new;
                n_t        = '0;
                if (r_elem == lbs_pkg::LAST_ELEM) begin
                    n_state = S_WRB;
                end else begin
                    n_elem  = r_elem + 1'b1;
                    n_state = S_MWAIT;
                end
            end
            S_WRB: begin
                n_state = S_IDLE;
            end
            S_RDOUT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid & ~o_out.ready;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_elem      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_elem      <= n_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vtx  <= n_vtx;
        r_vidx <= n_vidx;
        r_vok  <= n_vok;
        r_jnt  <= n_jnt;
        r_w    <= n_w;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_t    <= n_t;
        if (out_load) begin
            r_out_vtx <= r_vidx;
            if (r_vok) begin
                r_pos[0] <= acc_rd[3*lbs_pkg::COORD_W-1:2*lbs_pkg::COORD_W];
                r_pos[1] <= acc_rd[2*lbs_pkg::COORD_W-1:lbs_pkg::COORD_W];
                r_pos[2] <= acc_rd[lbs_pkg::COORD_W-1:0];
            end else begin
                r_pos[0] <= '0;
                r_pos[1] <= '0;
                r_pos[2] <= '0;
            end
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.out_vertex = r_out_vtx;
    assign o_out.pos_x      = r_pos[0];
    assign o_out.pos_y      = r_pos[1];
    assign o_out.pos_z      = r_pos[2];

    `LBS_ASSERT(a_elem_range, i_clk, i_rst_n, r_elem <= lbs_pkg::LAST_ELEM)
    `LBS_ASSERT_NEXT(a_fetch_to_mul, i_clk, i_rst_n, r_state == S_LOADB, r_state == S_MMUL)
    `LBS_ASSERT_NEXT(a_last_row_wb, i_clk, i_rst_n, r_state == S_WACC && r_elem == lbs_pkg::LAST_ELEM, r_state == S_WRB)
    `LBS_ASSERT_NEXT(a_read_delivers, i_clk, i_rst_n, out_load, o_out.valid && o_out.out_vertex == $past(r_vidx))

endmodule
